/* design/dedup_fifo_queue_macros.svh */
// assertion macros used by the checker file
`ifndef DEDUP_FIFO_QUEUE_MACROS_SVH
`define DEDUP_FIFO_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DFQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfq assertion failed");

// next-cycle implication, disabled while reset is held
`define DFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfq assertion failed");

`endif

/* design/dfq_pkg.sv */
// shared codes and controller/datapath interface types of the dedup queue
package dfq_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_DUP   = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } dfq_status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        load;        // capture accepted word
    logic        scan_start;  // begin duplicate search at head
    logic        scan_step;   // advance duplicate search
    logic        push;        // write value at tail
    logic        pop;         // drop head
    logic        set_status;  // record result status
    dfq_status_t status;
    logic        head_read;   // fetch head entry
    logic        out_load;    // fill output register
  } dfq_cmd_t;

  // flags from datapath to controller
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic empty;
    logic full;
    logic scan_hit;
    logic scan_over;
    logic out_free;
  } dfq_flags_t;

endpackage

/* design/dfq_ctrl.sv */
// controller state machine of the dedup queue
module dfq_ctrl
  import dfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dfq_flags_t flags,
  output dfq_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_HEAD   = 5'b01000,
    S_FINISH = 5'b10000
  } dfq_state_t;

  dfq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // no word is taken while reset is held
  assign in_ready = rst_n && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = STS_DONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (flags.is_push) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.set_status = 1'b1;
          if (flags.is_pop && flags.empty) begin
            cmd.status = STS_EMPTY;
          end else if (flags.is_pop) begin
            cmd.pop = 1'b1;
          end
          state_nxt = S_HEAD;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (flags.scan_hit) begin
          cmd.set_status = 1'b1;
          cmd.status     = STS_DUP;
          state_nxt      = S_HEAD;
        end else if (flags.scan_over) begin
          cmd.set_status = 1'b1;
          if (flags.full) begin
            cmd.status = STS_FULL;
          end else begin
            cmd.push = 1'b1;
          end
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head_read = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* design/dfq_datapath.sv */
// ring store, pointers, duplicate search and output register of the dedup queue
module dfq_datapath
  import dfq_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_value,
  input  dfq_cmd_t    cmd,
  output dfq_flags_t  flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_head_value,
  output logic        out_head_valid,
  output logic [4:0]  out_occupancy
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [1:0]             action_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [IDX_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]       scan_left_r, scan_left_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [VALUE_WIDTH-1:0] rd_data_r;
  dfq_status_t            status_r;

  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [31:0]            out_head_value_r;
  logic                   out_head_valid_r;
  logic [4:0]             out_occupancy_r;

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [63:0]            in_ext;
  logic [63:0]            head_ext;
  logic [31:0]            cnt_ext;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign in_ext   = 64'(in_value);
  assign head_ext = 64'(rd_data_r);
  assign cnt_ext  = 32'(count_r);

  // one read port shared by the search and the head fetch
  assign rd_en   = cmd.head_read || (cmd.scan_step && (scan_left_r != '0));
  assign rd_addr = cmd.head_read ? head_r : scan_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= value_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    scan_left_nxt = scan_left_r;
    cmp_vld_nxt   = cmp_vld_r;
    if (cmd.push) begin
      tail_nxt  = ring_next(tail_r);
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      head_nxt  = ring_next(head_r);
      count_nxt = count_r - 1'b1;
    end
    if (cmd.scan_start) begin
      scan_idx_nxt  = head_r;
      scan_left_nxt = count_r;
      cmp_vld_nxt   = 1'b0;
    end else if (cmd.scan_step) begin
      cmp_vld_nxt = (scan_left_r != '0);
      if (scan_left_r != '0) begin
        scan_idx_nxt  = ring_next(scan_idx_r);
        scan_left_nxt = scan_left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
      scan_left_r <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      scan_left_r <= scan_left_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      value_r  <= in_ext[VALUE_WIDTH-1:0];
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status_r     <= status_r;
      out_head_value_r <= (count_r != '0) ? head_ext[31:0] : '0;
      out_head_valid_r <= (count_r != '0);
      out_occupancy_r  <= cnt_ext[4:0];
    end
  end

  assign flags.is_push   = (action_r == ACT_PUSH);
  assign flags.is_pop    = (action_r == ACT_POP);
  assign flags.empty     = (count_r == '0);
  assign flags.full      = (count_r == FULL_CNT);
  assign flags.scan_hit  = cmp_vld_r && (rd_data_r == value_r);
  assign flags.scan_over = (scan_left_r == '0) && !cmp_vld_r;
  assign flags.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_head_value = out_head_value_r;
  assign out_head_valid = out_head_valid_r;
  assign out_occupancy  = out_occupancy_r;

endmodule

/* design/dedup_fifo_queue.sv */
// sequence: pop and peek words go through update, head fetch and finish steps
// before the result word loads; a push runs the duplicate search between update
// and head fetch (the search reads one entry per cycle), and a hit ends it early
// throughput: one word at a time; next accept in the cycle after the result loads,
// a stalled result word holds the finish step until the output register frees
// reset: synchronous active-low rst_n empties the queue and holds in_ready low;
// store contents stay undefined; an empty queue reports a zero head value
module dedup_fifo_queue
  import dfq_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_value,
  // result word channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_head_value,
  output logic        out_head_valid,
  output logic [4:0]  out_occupancy
);

  // control path: sequencer walks update, search (push only), head fetch, result load
  dfq_cmd_t   cmd;
  dfq_flags_t flags;

  dfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  // data path: ring store with one read port, pointers, output register
  dfq_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_value       (in_value),
    .cmd            (cmd),
    .flags          (flags),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_head_value (out_head_value),
    .out_head_valid (out_head_valid),
    .out_occupancy  (out_occupancy)
  );

endmodule

/* design/dfq_checker.sv */
// port-level checker of the dedup queue and its bind
`include "dedup_fifo_queue_macros.svh"

module dfq_checker
  import dfq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_head_value,
  input logic        out_head_valid,
  input logic [4:0]  out_occupancy
);

  // a stalled result word holds
  `DFQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_head_value) && $stable(out_occupancy))

  // one word in flight at a time
  `DFQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // empty queue reports zero head and zero occupancy
  `DFQ_ASSERT_NOW(a_empty_head, clk, rst_n, out_valid && !out_head_valid, out_occupancy == 5'd0 && out_head_value == 32'd0)

  // pop on empty leaves the queue empty
  `DFQ_ASSERT_NOW(a_pop_empty, clk, rst_n, out_valid && out_status == STS_EMPTY, !out_head_valid)

  // a duplicate implies something is held
  `DFQ_ASSERT_NOW(a_dup_held, clk, rst_n, out_valid && out_status == STS_DUP, out_head_valid)

endmodule

bind dedup_fifo_queue dfq_checker u_dfq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_head_value (out_head_value),
  .out_head_valid (out_head_valid),
  .out_occupancy  (out_occupancy)
);
